// ===== hdl/abts_pkg.sv =====
// Shared types, constants and codes for the alignment band tile stepper.
// Used by the interfaces, the configuration registers, the core and the top level.
package abts_pkg;

    localparam int COORD_BITS = 16;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [COORD_BITS:0]   t_wide;
    typedef logic [COORD_BITS+1:0] t_band;

    localparam t_wide BOUND_MAX = '1;
    localparam t_coord COORD_MAX = '1;
    localparam t_coord TILE_HEIGHT_RESET = t_coord'(64);

    typedef enum logic {
        ACT_START  = 1'b0,
        ACT_RESULT = 1'b1
    } t_action;

    typedef enum logic {
        ST_OK       = 1'b0,
        ST_NO_ALIGN = 1'b1
    } t_status;

    typedef enum logic [1:0] {
        CFG_PAT_LEN        = 2'd0,
        CFG_TILE_HEIGHT    = 2'd1,
        CFG_TEXT_LENGTH    = 2'd2,
        CFG_ERROR_LIMIT    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_coord pat_len;
        t_coord tile_height;
        t_coord text_length;
        t_coord error_limit;
    } t_cfg;

    typedef struct packed {
        t_action action;
        t_coord  match_column;
        t_coord  match_distance;
    } t_in_word;

    typedef struct packed {
        t_status status;
        t_coord  tile_start;
        t_wide   tile_width;
        t_coord  tile_rows;
        t_wide   path_bound;
        logic    finished;
    } t_out_word;

endpackage

// ===== hdl/abts_in_if.sv =====
// Input channel of the tile stepper: valid/ready handshake with the item fields.
// Depends on abts_pkg for the field types.
interface abts_in_if;
    logic                valid;
    logic                ready;
    abts_pkg::t_action   action;
    abts_pkg::t_coord    match_column;
    abts_pkg::t_coord    match_distance;

    modport source (output valid, action, match_column, match_distance, input ready);
    modport sink   (input valid, action, match_column, match_distance, output ready);
endinterface

// ===== hdl/abts_out_if.sv =====
// Result channel of the tile stepper: valid/ready handshake with the result fields.
// Depends on abts_pkg for the field types.
interface abts_out_if;
    logic                valid;
    logic                ready;
    abts_pkg::t_status   status;
    abts_pkg::t_coord    tile_start;
    abts_pkg::t_wide     tile_width;
    abts_pkg::t_coord    tile_rows;
    abts_pkg::t_wide     path_bound;
    logic                finished;

    modport source (output valid, status, tile_start, tile_width, tile_rows, path_bound,
                    finished, input ready);
    modport sink   (input valid, status, tile_start, tile_width, tile_rows, path_bound,
                    finished, output ready);
endinterface

// ===== hdl/abts_cfg.sv =====
// Configuration register file of the tile stepper, written through a plain write port.
// Depends on abts_pkg for the register index codes and the configuration struct.
module abts_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [1:0]        i_index,
    input  abts_pkg::t_coord  i_data,
    output abts_pkg::t_cfg    o_cfg
);

    abts_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pat_len        <= '0;
            r_cfg.tile_height    <= abts_pkg::TILE_HEIGHT_RESET;
            r_cfg.text_length    <= '0;
            r_cfg.error_limit    <= '0;
        end else if (i_we) begin
            unique case (abts_pkg::t_cfg_idx'(i_index))
                abts_pkg::CFG_PAT_LEN:        r_cfg.pat_len        <= i_data;
                abts_pkg::CFG_TILE_HEIGHT:    r_cfg.tile_height    <= i_data;
                abts_pkg::CFG_TEXT_LENGTH:    r_cfg.text_length    <= i_data;
                abts_pkg::CFG_ERROR_LIMIT:    r_cfg.error_limit    <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/abts_core.sv =====
// Tiling state and the single-pass datapath that turns one word into one result.
// Depends on abts_pkg; the top level supplies the registered input word and config.
module abts_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  abts_pkg::t_in_word   i_word,
    input  abts_pkg::t_cfg       i_cfg,
    output abts_pkg::t_out_word  o_result
);

    localparam int CB = abts_pkg::COORD_BITS;
    localparam int SW = CB + 4;
    localparam logic signed [SW-1:0] ONE_S = 1;

    abts_pkg::t_band  r_band_width, n_band_width;
    abts_pkg::t_coord r_rows_left, n_rows_left;
    abts_pkg::t_coord r_offset, n_offset;
    abts_pkg::t_coord r_step, n_step;
    abts_pkg::t_coord r_cur_rows, n_cur_rows;
    abts_pkg::t_wide  r_cur_width, n_cur_width;
    abts_pkg::t_wide  r_prev_match, n_prev_match;
    logic             r_prev_valid, n_prev_valid;

    logic [CB+1:0]        w_pos2e;
    logic                 w_no_align;
    logic [CB:0]          w_off_sum;
    abts_pkg::t_wide      w_pos;
    logic signed [SW-1:0] w_proj, w_lo, w_hi, w_upper, w_pm, w_d1, w_d2, w_m;
    abts_pkg::t_wide      w_bound;
    logic [CB+2:0]        w_wsum;
    logic [CB+3:0]        w_end;
    abts_pkg::t_status    w_status;

    always_comb begin
        n_band_width = r_band_width;
        n_rows_left  = r_rows_left;
        n_offset     = r_offset;
        n_step       = r_step;
        n_cur_rows   = r_cur_rows;
        n_prev_match = r_prev_match;
        n_prev_valid = r_prev_valid;
        w_status     = abts_pkg::ST_OK;
        w_bound      = '0;

        w_pos2e    = {2'b00, i_cfg.text_length} + {1'b0, i_cfg.error_limit, 1'b0};
        w_no_align = w_pos2e < {2'b00, i_cfg.pat_len};
        w_off_sum  = {1'b0, r_offset} + {1'b0, r_step};

        w_pos   = {1'b0, i_word.match_column} + {1'b0, r_offset};
        w_proj  = $signed({3'b000, w_pos}) - $signed({4'b0000, r_cur_rows});
        w_lo    = w_proj - $signed({4'b0000, i_word.match_distance});
        if (w_lo[SW-1]) begin
            w_lo = '0;
        end
        w_upper = $signed({4'b0000, i_cfg.text_length}) - ONE_S;
        w_hi    = w_proj + $signed({4'b0000, i_word.match_distance});
        if (w_hi > w_upper) begin
            w_hi = w_upper;
        end
        w_pm = $signed({3'b000, r_prev_match});
        w_d1 = w_pm - w_lo;
        if (w_d1[SW-1]) begin
            w_d1 = -w_d1;
        end
        w_d2 = w_pm - w_hi;
        if (w_d2[SW-1]) begin
            w_d2 = -w_d2;
        end
        w_m = (w_d1 > w_d2) ? w_d1 : w_d2;

        case (i_word.action)
            abts_pkg::ACT_START: begin
                n_offset     = '0;
                n_prev_match = '0;
                n_prev_valid = 1'b0;
                if (w_no_align) begin
                    w_status     = abts_pkg::ST_NO_ALIGN;
                    n_band_width = '0;
                    n_rows_left  = '0;
                    n_step       = '0;
                    n_cur_rows   = '0;
                end else begin
                    n_band_width = w_pos2e - {2'b00, i_cfg.pat_len};
                    n_rows_left  = i_cfg.pat_len;
                    n_step       = (i_cfg.tile_height > i_cfg.error_limit) ?
                                   i_cfg.tile_height - i_cfg.error_limit : '0;
                    n_cur_rows   = (i_cfg.pat_len > i_cfg.tile_height) ?
                                   i_cfg.tile_height : i_cfg.pat_len;
                end
            end
            default: begin
                if (!r_prev_valid) begin
                    n_prev_match = {1'b0, i_word.match_column};
                    n_prev_valid = 1'b1;
                end else begin
                    n_prev_match = w_pos;
                    w_bound = (w_m > $signed({3'b000, abts_pkg::BOUND_MAX})) ?
                              abts_pkg::BOUND_MAX : w_m[CB:0];
                end
                n_offset    = w_off_sum[CB] ? abts_pkg::COORD_MAX : w_off_sum[CB-1:0];
                n_rows_left = r_rows_left - r_cur_rows;
                n_step      = r_cur_rows;
                n_cur_rows  = (n_rows_left < r_cur_rows) ? n_rows_left : r_cur_rows;
            end
        endcase

        // The tile is clipped so that it never runs past the end of the text.
        w_wsum = {1'b0, n_band_width} + {3'b000, n_step};
        w_end  = {4'b0000, n_offset} + {1'b0, w_wsum};
        if (n_offset >= i_cfg.text_length) begin
            n_cur_width = '0;
        end else if (w_end > {4'b0000, i_cfg.text_length}) begin
            n_cur_width = {1'b0, i_cfg.text_length} - {1'b0, n_offset};
        end else begin
            n_cur_width = w_wsum[CB:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_width <= '0;
            r_rows_left  <= '0;
            r_offset     <= '0;
            r_step       <= '0;
            r_cur_rows   <= '0;
            r_cur_width  <= '0;
            r_prev_match <= '0;
            r_prev_valid <= 1'b0;
        end else if (i_fire) begin
            r_band_width <= n_band_width;
            r_rows_left  <= n_rows_left;
            r_offset     <= n_offset;
            r_step       <= n_step;
            r_cur_rows   <= n_cur_rows;
            r_cur_width  <= n_cur_width;
            r_prev_match <= n_prev_match;
            r_prev_valid <= n_prev_valid;
        end
    end

    always_comb begin
        o_result.status     = w_status;
        o_result.tile_start = n_offset;
        o_result.tile_width = n_cur_width;
        o_result.tile_rows  = n_cur_rows;
        o_result.path_bound = w_bound;
        o_result.finished   = (n_rows_left == '0);
    end

    // The current tile never holds more rows than remain in the pattern.
    a_rows_within_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_rows <= r_rows_left)
        else $error("tile rows exceed remaining rows");

    // A start that cannot align leaves an empty, finished tiling.
    a_no_align_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.status == abts_pkg::ST_NO_ALIGN) |->
        (o_result.finished && o_result.tile_rows == '0 && o_result.tile_width == '0))
        else $error("failed start produced a non-empty tiling");

    // A clipped tile width always fits within the text coordinate range.
    a_width_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cur_width[CB])
        else $error("tile width beyond text coordinate range");

endmodule

// ===== hdl/alignment_band_tile_stepper.sv =====
// Top level of the alignment band tile stepper: input register, core and result register.
// Depends on abts_pkg, abts_in_if, abts_out_if, abts_cfg and abts_core.
//
// The block accepts one word per clock cycle while its result side is not stalled, and returns
// exactly one result word for each, in order. A word is registered at acceptance and processed
// once the result register can take it, when the tiling state is updated and the result
// register is loaded; the rate is set by the single state update stage. A stalled result
// register holds the pipeline without losing words.
// Configuration writes take effect at once and should be made while no word is in flight.
module alignment_band_tile_stepper (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  abts_pkg::t_coord  i_cfg_data,
    abts_in_if.sink           i_item,
    abts_out_if.source        o_result
);

    abts_pkg::t_cfg       w_cfg;
    abts_pkg::t_in_word   r_s1_word;
    logic                 r_s1_valid, n_s1_valid;
    abts_pkg::t_out_word  r_out_word, w_core_result;
    logic                 r_out_valid, n_out_valid;
    logic                 w_advance, w_fire, w_take;

    assign w_advance = !r_out_valid || o_result.ready;
    assign w_fire    = r_s1_valid && w_advance;
    assign w_take    = i_item.valid && i_item.ready;

    assign i_item.ready = !r_s1_valid || w_advance;

    assign n_s1_valid  = w_take ? 1'b1 : (w_fire ? 1'b0 : r_s1_valid);
    assign n_out_valid = w_fire ? 1'b1 : (o_result.ready ? 1'b0 : r_out_valid);

    abts_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    abts_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_word   (r_s1_word),
        .i_cfg    (w_cfg),
        .o_result (w_core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_s1_word.action         <= i_item.action;
            r_s1_word.match_column   <= i_item.match_column;
            r_s1_word.match_distance <= i_item.match_distance;
        end
        if (w_fire) begin
            r_out_word <= w_core_result;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.status     = r_out_word.status;
    assign o_result.tile_start = r_out_word.tile_start;
    assign o_result.tile_width = r_out_word.tile_width;
    assign o_result.tile_rows  = r_out_word.tile_rows;
    assign o_result.path_bound = r_out_word.path_bound;
    assign o_result.finished   = r_out_word.finished;

    // A processed word always lands in the result register.
    a_fire_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("processed word did not reach the result register");

    // A registered word that cannot advance stays in the input register.
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_advance) |=> (r_s1_valid && $stable(r_s1_word)))
        else $error("stalled input word was lost");

    // The input side is never ready while both stages are full and stalled.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !o_result.ready) |-> !i_item.ready)
        else $error("word accepted into a full pipeline");

endmodule

// ===== tb/sv/tb_alignment_band_tile_stepper.sv =====
// Self-checking testbench for alignment_band_tile_stepper: drives start and tile-result words
// under random idling and a long output stall, and checks every result against a tiling predictor.
// Depends on abts_pkg, abts_in_if, abts_out_if and the block itself.
module tb_alignment_band_tile_stepper;
    import abts_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int LONG_HOLD    = 60;
    localparam int MAX_REPORTS  = 10;
    localparam int RANDOM_WORDS = 450;
    localparam int QUIET_AFTER  = 380;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [1:0] i_cfg_index = '0;
    t_coord     i_cfg_data  = '0;

    abts_in_if  item_if ();
    abts_out_if result_if ();

    alignment_band_tile_stepper i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (item_if),
        .o_result    (result_if)
    );

    always #4 i_clk = ~i_clk;

    t_in_word  pending_words[$];
    t_out_word expected_tiles[$];

    t_cfg   regs_model;
    t_band  band_w;
    t_coord rows_rem;
    t_coord tile_off;
    t_coord off_step;
    t_coord cur_rows;
    t_wide  cur_cols;
    t_wide  last_match;
    logic   last_match_ok;

    t_in_word  next_word;
    t_in_word  taken_word;
    t_out_word got_tile;
    t_out_word want_tile;
    logic      word_taken   = 1'b0;
    bit        src_idle     = 1'b1;
    bit        sink_idle    = 1'b1;
    bit        sink_hold    = 1'b0;
    bit        hold_request = 1'b0;
    int        src_gap      = 0;
    int        sink_gap     = 0;
    int        hold_cycles  = 0;
    int        cycle_count  = 0;
    int        words_taken  = 0;
    int        starts_taken = 0;
    int        refused_seen = 0;
    int        results_seen = 0;
    int        fail_count   = 0;
    int        settings_used = 0;
    int        random_words = 0;

    function automatic t_wide clip_to_text();
        int span;
        int stp;
        int o;
        int txt;
        span = band_w;
        stp  = off_step;
        o    = tile_off;
        txt  = regs_model.text_length;
        span = span + stp;
        if (o >= txt) return '0;
        if (o + span > txt) span = txt - o;
        return t_wide'(span);
    endfunction

    function automatic t_wide band_path_bound(t_coord col, t_coord distance);
        int c;
        int d;
        int o;
        int rows;
        int pm;
        int pos;
        int proj;
        int lo;
        int hi;
        int upper;
        int d1;
        int d2;
        int far;
        c     = col;
        d     = distance;
        o     = tile_off;
        rows  = cur_rows;
        pm    = last_match;
        upper = regs_model.text_length;
        upper = upper - 1;
        pos   = c + o;
        if (!last_match_ok) begin
            last_match    = t_wide'(col);
            last_match_ok = 1'b1;
            return '0;
        end
        proj = pos - rows;
        lo = proj - d;
        if (lo < 0) lo = 0;
        hi = proj + d;
        if (hi > upper) hi = upper;
        d1 = pm - lo;
        if (d1 < 0) d1 = -d1;
        d2 = pm - hi;
        if (d2 < 0) d2 = -d2;
        far = d1 > d2 ? d1 : d2;
        last_match = t_wide'(pos);
        if (far > int'(BOUND_MAX)) return BOUND_MAX;
        return t_wide'(far);
    endfunction

    function automatic t_out_word step_tiling(t_in_word w);
        t_out_word r;
        int plen;
        int h;
        int e;
        int reach;
        int nxt;
        int stp;
        r = '0;
        if (w.action == ACT_START) begin
            plen  = regs_model.pat_len;
            h     = regs_model.tile_height;
            e     = regs_model.error_limit;
            reach = regs_model.text_length;
            reach = reach + 2 * e;
            tile_off      = '0;
            last_match    = '0;
            last_match_ok = 1'b0;
            if (reach < plen) begin
                r.status = ST_NO_ALIGN;
                band_w   = '0;
                rows_rem = '0;
                off_step = '0;
                cur_rows = '0;
                cur_cols = '0;
            end else begin
                band_w   = t_band'(reach - plen);
                rows_rem = t_coord'(plen);
                off_step = h > e ? t_coord'(h - e) : '0;
                cur_rows = plen > h ? t_coord'(h) : t_coord'(plen);
                cur_cols = clip_to_text();
            end
        end else begin
            r.path_bound = band_path_bound(w.match_column, w.match_distance);
            nxt = tile_off;
            stp = off_step;
            nxt = nxt + stp;
            tile_off = nxt > int'(COORD_MAX) ? COORD_MAX : t_coord'(nxt);
            rows_rem = rows_rem - cur_rows;
            off_step = cur_rows;
            if (rows_rem < cur_rows) cur_rows = rows_rem;
            cur_cols = clip_to_text();
        end
        r.tile_start = tile_off;
        r.tile_width = cur_cols;
        r.tile_rows  = cur_rows;
        r.finished   = (rows_rem == '0);
        return r;
    endfunction

    function automatic t_coord pick_coord(int unsigned typical);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return COORD_MAX;
            2: return t_coord'($urandom);
            default: return t_coord'($urandom_range(0, typical));
        endcase
    endfunction

    task automatic note_failure(string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("mismatch: %s", what);
    endtask

    task automatic queue_word(t_action act, t_coord col, t_coord dist_val);
        t_in_word w;
        w.action         = act;
        w.match_column   = col;
        w.match_distance = dist_val;
        pending_words.push_back(w);
    endtask

    task automatic write_reg(t_cfg_idx idx, t_coord value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            CFG_PAT_LEN:        regs_model.pat_len        = value;
            CFG_TILE_HEIGHT:    regs_model.tile_height    = value;
            CFG_TEXT_LENGTH:    regs_model.text_length    = value;
            CFG_ERROR_LIMIT:    regs_model.error_limit    = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all(t_coord plen, t_coord h, t_coord txt, t_coord e);
        write_reg(CFG_PAT_LEN, plen);
        write_reg(CFG_TILE_HEIGHT, h);
        write_reg(CFG_TEXT_LENGTH, txt);
        write_reg(CFG_ERROR_LIMIT, e);
        settings_used++;
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || item_if.valid || expected_tiles.size() != 0
               || sink_hold)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("timeout with %0d results outstanding", expected_tiles.size());
            $display("FAIL");
            $finish;
        end
    end

    // Word acceptance and result checking share one process so that the expectation
    // of a word is always queued before any result is compared.
    always @(posedge i_clk) begin
        word_taken <= item_if.valid && item_if.ready;
        if (i_rst_n && item_if.valid && item_if.ready) begin
            taken_word.action         = item_if.action;
            taken_word.match_column   = item_if.match_column;
            taken_word.match_distance = item_if.match_distance;
            expected_tiles.push_back(step_tiling(taken_word));
            words_taken++;
            if (taken_word.action == ACT_START) starts_taken++;
        end
        if (i_rst_n && result_if.valid && result_if.ready) begin
            got_tile.status     = result_if.status;
            got_tile.tile_start = result_if.tile_start;
            got_tile.tile_width = result_if.tile_width;
            got_tile.tile_rows  = result_if.tile_rows;
            got_tile.path_bound = result_if.path_bound;
            got_tile.finished   = result_if.finished;
            results_seen++;
            if (got_tile.status == ST_NO_ALIGN) refused_seen++;
            if (expected_tiles.size() == 0) begin
                note_failure($sformatf("result %0d arrived with nothing expected", results_seen));
            end else begin
                want_tile = expected_tiles.pop_front();
                if (got_tile.status !== want_tile.status
                    || got_tile.tile_start !== want_tile.tile_start
                    || got_tile.tile_width !== want_tile.tile_width
                    || got_tile.tile_rows !== want_tile.tile_rows
                    || got_tile.path_bound !== want_tile.path_bound
                    || got_tile.finished !== want_tile.finished)
                    note_failure({
                        $sformatf("result %0d status/start/width/rows/bound/finished ",
                                  results_seen),
                        $sformatf("%0d/%0d/%0d/%0d/%0d/%0d, ",
                                  got_tile.status, got_tile.tile_start, got_tile.tile_width,
                                  got_tile.tile_rows, got_tile.path_bound, got_tile.finished),
                        $sformatf("expected %0d/%0d/%0d/%0d/%0d/%0d",
                                  want_tile.status, want_tile.tile_start, want_tile.tile_width,
                                  want_tile.tile_rows, want_tile.path_bound,
                                  want_tile.finished)});
            end
        end
    end

    always @(negedge i_clk) begin
        if (!item_if.valid || word_taken) begin
            if (src_gap > 0) begin
                src_gap--;
                item_if.valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                next_word = pending_words.pop_front();
                item_if.valid          <= 1'b1;
                item_if.action         <= next_word.action;
                item_if.match_column   <= next_word.match_column;
                item_if.match_distance <= next_word.match_distance;
                if (src_idle && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 19);
            end else begin
                item_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || sink_hold) begin
            result_if.ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            result_if.ready <= 1'b0;
        end else begin
            result_if.ready <= 1'b1;
            if (sink_idle && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 19);
        end
    end

    initial begin
        @(posedge hold_request);
        @(negedge i_clk);
        sink_hold <= 1'b1;
        for (hold_cycles = 0; hold_cycles < LONG_HOLD; hold_cycles++) @(negedge i_clk);
        sink_hold <= 1'b0;
    end

    initial begin
        int     k;
        int     words_in_phase;
        int     phase_no;
        bit     live_only;
        t_coord h_pick;

        item_if.valid          = 1'b0;
        item_if.action         = ACT_START;
        item_if.match_column   = '0;
        item_if.match_distance = '0;
        result_if.ready        = 1'b0;

        regs_model.pat_len        = '0;
        regs_model.tile_height    = TILE_HEIGHT_RESET;
        regs_model.text_length    = '0;
        regs_model.error_limit    = '0;
        band_w        = '0;
        rows_rem      = '0;
        tile_off      = '0;
        off_step      = '0;
        cur_rows      = '0;
        cur_cols      = '0;
        last_match    = '0;
        last_match_ok = 1'b0;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Tile results before any start, then a start and a result on the reset settings.
        settings_used++;
        queue_word(ACT_RESULT, 16'd40, 16'd3);
        queue_word(ACT_RESULT, 16'd7, 16'd0);
        queue_word(ACT_START, 16'd0, 16'd0);
        queue_word(ACT_RESULT, 16'd0, 16'd0);
        wait_drained();

        // Normal tiling run to its end and one result past the finish.
        write_all(16'd100, 16'd40, 16'd150, 16'd8);
        queue_word(ACT_START, 16'hFFFF, 16'hFFFF);
        queue_word(ACT_RESULT, 16'd0, 16'd0);
        queue_word(ACT_RESULT, 16'hFFFF, 16'hFFFF);
        queue_word(ACT_RESULT, 16'd20, 16'd3);
        queue_word(ACT_RESULT, 16'd5, 16'd1);
        wait_drained();

        // Negative band: the start is refused and leaves a finished, empty tiling.
        write_all(16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
        queue_word(ACT_START, 16'd0, 16'd0);
        queue_word(ACT_RESULT, 16'd12, 16'd2);
        wait_drained();

        // Error limit above the tile height gives a zero first offset step.
        write_all(16'd30, 16'd5, 16'd200, 16'd20);
        queue_word(ACT_START, 16'd0, 16'd0);
        queue_word(ACT_RESULT, 16'd3, 16'd1);
        queue_word(ACT_RESULT, 16'd9, 16'd4);
        wait_drained();

        // Tile offset saturates at the coordinate maximum.
        write_all(16'hFFFF, 16'd40000, 16'hFFFF, 16'd0);
        queue_word(ACT_START, 16'd0, 16'd0);
        queue_word(ACT_RESULT, 16'hFFFF, 16'd0);
        queue_word(ACT_RESULT, 16'd0, 16'hFFFF);
        queue_word(ACT_RESULT, 16'hFFFF, 16'hFFFF);
        wait_drained();

        // Empty text with the widest error limit.
        write_all(16'd10, 16'd4, 16'd0, 16'hFFFF);
        queue_word(ACT_START, 16'd0, 16'd0);
        queue_word(ACT_RESULT, 16'd2, 16'd1);
        queue_word(ACT_RESULT, 16'd300, 16'd9);
        wait_drained();

        // Text length changed in the middle of a tiling takes effect at once.
        write_reg(CFG_TEXT_LENGTH, 16'd300);
        settings_used++;
        queue_word(ACT_RESULT, 16'd1, 16'd2);
        wait_drained();

        phase_no = 0;
        while (random_words < RANDOM_WORDS) begin
            src_idle  = random_words < QUIET_AFTER;
            sink_idle = random_words < QUIET_AFTER;
            live_only = phase_no > 0 && $urandom_range(0, 5) == 0;
            if (live_only) begin
                write_reg(CFG_TEXT_LENGTH, pick_coord(400));
            end else begin
                if (phase_no == 0 || $urandom_range(0, 3) != 0)
                    write_reg(CFG_PAT_LEN, pick_coord(300));
                if (phase_no == 0 || $urandom_range(0, 3) != 0) begin
                    h_pick = pick_coord(64);
                    if (h_pick == '0) h_pick = 16'd1;
                    write_reg(CFG_TILE_HEIGHT, h_pick);
                end
                if (phase_no == 0 || $urandom_range(0, 3) != 0)
                    write_reg(CFG_TEXT_LENGTH, pick_coord(400));
                if (phase_no == 0 || $urandom_range(0, 3) != 0)
                    write_reg(CFG_ERROR_LIMIT, pick_coord(40));
            end
            settings_used++;
            words_in_phase = $urandom_range(8, 20);
            if (phase_no == 2) begin
                // Output held off while the sender keeps offering, so the block backs up.
                src_idle       = 1'b0;
                words_in_phase = 40;
                hold_request   = 1'b1;
            end
            for (k = 0; k < words_in_phase; k++) begin
                if ((k == 0 && !live_only) || $urandom_range(0, 9) == 0)
                    queue_word(ACT_START, t_coord'($urandom), t_coord'($urandom));
                else
                    queue_word(ACT_RESULT, pick_coord(200), pick_coord(30));
            end
            random_words += words_in_phase;
            phase_no++;
            wait_drained();
        end

        repeat (6) @(negedge i_clk);
        $display("Checked %0d words (%0d starts, %0d refused for a negative band)",
                 words_taken, starts_taken, refused_seen);
        $display("over %0d settings, with random idling on both sides and one %0d-cycle stall.",
                 settings_used, LONG_HOLD);
        if (fail_count == 0 && expected_tiles.size() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d failures", fail_count);
            $display("FAIL");
        end
        $finish;
    end

endmodule
